// File: src/fbde_pkg.sv
// Shared types, constants and functions of the four-button debounce event generator.
package fbde_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int LEVEL_W = 4;
	localparam int TIME_W = 32;
	localparam int CFG_W = 16;
	localparam int CODE_W = 4;

	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_REPEAT_START = 2'd1;
	localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd2;
	localparam logic [1:0] REG_LONG_PRESS = 2'd3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] REPEAT_START_RST = 16'd500;
	localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

	localparam logic [CODE_W-1:0] EV_NONE = 4'd0;
	localparam logic [CODE_W-1:0] EV_MAX = 4'd15;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] repeat_start_time;
		logic [CFG_W-1:0] repeat_interval;
		logic [CFG_W-1:0] long_press_time;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] ref_time;
		logic [CFG_W-1:0] threshold;
		logic or_equal;
	} cmp_req_t;

	function automatic logic [CODE_W-1:0] short_code(input logic [CODE_W-1:0] b);
		return b + 4'd1;
	endfunction

	function automatic logic [CODE_W-1:0] long_code(input int nb, input logic [CODE_W-1:0] b);
		int c;
		c = nb + 1 + int'(b);
		return (c > 15) ? EV_MAX : CODE_W'(c);
	endfunction

endpackage

// File: src/fbde_cmp.sv
// Shared elapsed-time unit: subtracts a stored time from now and compares against a threshold.
module fbde_cmp
	import fbde_pkg::*;
(
	input  logic [TIME_W-1:0] now_ms,
	input  cmp_req_t          req,
	output logic              hit
);

	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] limit;

	assign elapsed = now_ms - req.ref_time;
	assign limit = TIME_W'(req.threshold);
	assign hit = req.or_equal ? (elapsed >= limit) : (elapsed > limit);

endmodule

// File: src/fbde_seq.sv
// Sequencer and per-button state that walk the buttons of one poll through the shared unit.
module fbde_seq
	import fbde_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TIME_W-1:0]  now_in,
	input  logic [LEVEL_W-1:0] levels_in,
	input  cfg_t               cfg,
	input  logic               res_take,
	input  logic               cmp_hit,
	output cmp_req_t           cmp_req,
	output logic [TIME_W-1:0]  now_ms,
	output logic               idle,
	output logic               res_valid,
	output logic [CODE_W-1:0]  res_code
);

	localparam int BW = $clog2(NUM_BUTTONS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEB = 3'd1;
	localparam logic [2:0] S_REP = 3'd2;
	localparam logic [2:0] S_LNG = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [BW-1:0] btn_q;
	logic [TIME_W-1:0] now_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [CODE_W-1:0] code_q;

	logic [NUM_BUTTONS-1:0] sp_q;
	logic [NUM_BUTTONS-1:0] lraw_q;
	logic [NUM_BUTTONS-1:0] rep_q;
	logic [NUM_BUTTONS-1:0] lf_q;
	logic [TIME_W-1:0] rct_q [NUM_BUTTONS];
	logic [TIME_W-1:0] ps_q [NUM_BUTTONS];
	logic [TIME_W-1:0] lr_q [NUM_BUTTONS];

	logic [NUM_BUTTONS-1:0] raw_vec;
	logic raw;
	logic changed;
	logic last_btn;
	logic repeat_btn;
	logic [2:0] adv_state;
	logic [CODE_W-1:0] btn_ext;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_raw
		if (i < LEVEL_W) begin : g_in
			assign raw_vec[i] = lvl_q[i];
		end else begin : g_off
			assign raw_vec[i] = 1'b0;
		end
	end

	assign raw = raw_vec[btn_q];
	assign changed = raw != lraw_q[btn_q];
	assign last_btn = btn_q == BW'(NUM_BUTTONS - 1);
	assign repeat_btn = btn_q <= BW'(1);
	assign adv_state = last_btn ? S_DONE : S_DEB;
	assign btn_ext = CODE_W'(btn_q);

	always_comb begin
		cmp_req.ref_time = rct_q[btn_q];
		cmp_req.threshold = cfg.debounce_time;
		cmp_req.or_equal = 1'b0;
		unique case (state_q)
			S_REP: begin
				cmp_req.ref_time = rep_q[btn_q] ? lr_q[btn_q] : ps_q[btn_q];
				cmp_req.threshold = rep_q[btn_q] ? cfg.repeat_interval : cfg.repeat_start_time;
				cmp_req.or_equal = 1'b1;
			end
			S_LNG: begin
				cmp_req.ref_time = ps_q[btn_q];
				cmp_req.threshold = cfg.long_press_time;
				cmp_req.or_equal = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign now_ms = now_q;
	assign idle = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res_code = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			btn_q <= '0;
			code_q <= EV_NONE;
			sp_q <= '0;
			lraw_q <= '0;
			rep_q <= '0;
			lf_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				rct_q[i] <= '0;
				ps_q[i] <= '0;
				lr_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						btn_q <= '0;
						state_q <= S_DEB;
					end
				end
				S_DEB: begin
					if (changed) begin
						lraw_q[btn_q] <= raw;
						rct_q[btn_q] <= now_q;
					end
					if (!changed && cmp_hit && raw != sp_q[btn_q]) begin
						sp_q[btn_q] <= raw;
						if (raw) begin
							rep_q[btn_q] <= 1'b0;
							lf_q[btn_q] <= 1'b0;
							ps_q[btn_q] <= now_q;
							code_q <= short_code(btn_ext);
							state_q <= S_DONE;
						end else begin
							state_q <= adv_state;
							btn_q <= btn_q + 1'b1;
							code_q <= EV_NONE;
						end
					end else if (sp_q[btn_q] && repeat_btn) begin
						state_q <= S_REP;
					end else if (sp_q[btn_q] && !lf_q[btn_q]) begin
						state_q <= S_LNG;
					end else begin
						state_q <= adv_state;
						btn_q <= btn_q + 1'b1;
						code_q <= EV_NONE;
					end
				end
				S_REP: begin
					if (cmp_hit) begin
						rep_q[btn_q] <= 1'b1;
						lr_q[btn_q] <= now_q;
						code_q <= short_code(btn_ext);
						state_q <= S_DONE;
					end else if (!lf_q[btn_q]) begin
						state_q <= S_LNG;
					end else begin
						state_q <= adv_state;
						btn_q <= btn_q + 1'b1;
						code_q <= EV_NONE;
					end
				end
				S_LNG: begin
					if (cmp_hit) begin
						lf_q[btn_q] <= 1'b1;
						code_q <= long_code(NUM_BUTTONS, btn_ext);
						state_q <= S_DONE;
					end else begin
						state_q <= adv_state;
						btn_q <= btn_q + 1'b1;
						code_q <= EV_NONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			now_q <= now_in;
			lvl_q <= levels_in;
		end
	end

endmodule

// File: src/four_button_debounce_event_generator.sv
// Top level of the four-button debounce event generator.
// Each poll transaction carries a millisecond timestamp and the raw button levels, and yields
// exactly one event code (0 when nothing happened). The sequencer takes the transaction, then
// runs each elapsed-time test in a state of its own on the single shared subtract-and-compare
// unit, then hands the result to the output register. Every button gets a debounce test.
// Buttons 0 and 1 also get a repeat test while held, and every held button whose long press
// has not yet fired gets a long-press test. The poll stops at the first event, so a press of
// button 0 gives the shortest poll. The longest poll has every held button without an event.
// A stalled output holds the result and delays the next poll. The input is not ready while a
// poll is in progress.
// The configuration channel is always ready and should be written only between polls.
module four_button_debounce_event_generator
	import fbde_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // now_ms[31:0], button_levels[35:32], zero[39:36]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // event_code[3:0], zero[7:4]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	cmp_req_t cmp_req;
	logic cmp_hit;
	logic [TIME_W-1:0] now_ms;
	logic idle;
	logic res_valid;
	logic [CODE_W-1:0] res_code;
	logic res_take;
	logic out_valid_q;
	logic [CODE_W-1:0] out_code_q;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = idle;
	assign res_take = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'd0, out_code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DEBOUNCE_RST;
			cfg_q.repeat_start_time <= REPEAT_START_RST;
			cfg_q.repeat_interval <= REPEAT_INTERVAL_RST;
			cfg_q.long_press_time <= LONG_PRESS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_time <= cfg_data;
				REG_REPEAT_START: cfg_q.repeat_start_time <= cfg_data;
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_data;
				REG_LONG_PRESS: cfg_q.long_press_time <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_code_q <= res_code;
		end
	end

	fbde_seq #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(s_axis_tvalid),
		.now_in(s_axis_tdata[31:0]),
		.levels_in(s_axis_tdata[35:32]),
		.cfg(cfg_q),
		.res_take(res_take),
		.cmp_hit(cmp_hit),
		.cmp_req(cmp_req),
		.now_ms(now_ms),
		.idle(idle),
		.res_valid(res_valid),
		.res_code(res_code)
	);

	fbde_cmp u_cmp (
		.now_ms(now_ms),
		.req(cmp_req),
		.hit(cmp_hit)
	);

endmodule

// File: src/fbde_chk.sv
// Port-level checker of the four-button debounce event generator, bound to the top level.
module fbde_chk
	import fbde_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	localparam int MAX_CODE_I = (2 * NUM_BUTTONS > 15) ? 15 : 2 * NUM_BUTTONS;
	localparam logic [CODE_W-1:0] MAX_CODE = CODE_W'(MAX_CODE_I);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped before it was taken");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] <= MAX_CODE && m_axis_tdata[7:4] == 4'd0)
		else $error("event code out of range");

	a_busy_after_poll: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready while a poll is in progress");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared too soon after a poll");

endmodule

bind four_button_debounce_event_generator fbde_chk #(
	.NUM_BUTTONS(NUM_BUTTONS)
) u_fbde_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

// File: tb/sv/tb_four_button_debounce_event_generator.sv
// Self-checking testbench for the four-button debounce event generator.
`timescale 1ns / 100ps

module tb_four_button_debounce_event_generator;
	import fbde_pkg::*;

	// Tracks the debounce and hold state of every button and predicts the event of each poll.
	class button_event_tracker;
		cfg_t timing;
		logic [NUM_BUTTONS_DEF-1:0] held_state;
		logic [NUM_BUTTONS_DEF-1:0] last_level;
		logic [NUM_BUTTONS_DEF-1:0] repeating;
		logic [NUM_BUTTONS_DEF-1:0] long_done;
		logic [TIME_W-1:0] change_at [NUM_BUTTONS_DEF];
		logic [TIME_W-1:0] press_at [NUM_BUTTONS_DEF];
		logic [TIME_W-1:0] repeat_at [NUM_BUTTONS_DEF];
		logic [CODE_W-1:0] pending_codes [$];
		int errors;

		function new();
			timing = '{DEBOUNCE_RST, REPEAT_START_RST, REPEAT_INTERVAL_RST, LONG_PRESS_RST};
			held_state = '0;
			last_level = '0;
			repeating = '0;
			long_done = '0;
			foreach (change_at[i]) begin
				change_at[i] = '0;
				press_at[i] = '0;
				repeat_at[i] = '0;
			end
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_DEBOUNCE: timing.debounce_time = val;
				REG_REPEAT_START: timing.repeat_start_time = val;
				REG_REPEAT_INTERVAL: timing.repeat_interval = val;
				REG_LONG_PRESS: timing.long_press_time = val;
				default: ;
			endcase
		endfunction

		function logic [CODE_W-1:0] next_event(logic [TIME_W-1:0] now_ms,
				logic [LEVEL_W-1:0] levels);
			int b;
			int c;
			logic raw;
			logic [TIME_W-1:0] since;
			logic [TIME_W-1:0] held;
			for (b = 0; b < NUM_BUTTONS_DEF; b++) begin
				raw = (b < LEVEL_W) ? levels[b] : 1'b0;
				if (raw != last_level[b]) begin
					change_at[b] = now_ms;
					last_level[b] = raw;
				end
				since = now_ms - change_at[b];
				if (since > timing.debounce_time && raw != held_state[b]) begin
					held_state[b] = raw;
					if (raw) begin
						repeating[b] = 1'b0;
						long_done[b] = 1'b0;
						press_at[b] = now_ms;
						return CODE_W'(b + 1);
					end
				end
				if (held_state[b]) begin
					held = now_ms - press_at[b];
					if (b < 2) begin
						if (!repeating[b] && held >= timing.repeat_start_time) begin
							repeating[b] = 1'b1;
							repeat_at[b] = now_ms;
							return CODE_W'(b + 1);
						end
						since = now_ms - repeat_at[b];
						if (repeating[b] && since >= timing.repeat_interval) begin
							repeat_at[b] = now_ms;
							return CODE_W'(b + 1);
						end
					end
					if (!long_done[b] && held >= timing.long_press_time) begin
						long_done[b] = 1'b1;
						c = NUM_BUTTONS_DEF + 1 + b;
						return (c > 15) ? EV_MAX : CODE_W'(c);
					end
				end
			end
			return EV_NONE;
		endfunction

		function void take_poll(logic [TIME_W-1:0] now_ms, logic [LEVEL_W-1:0] levels);
			pending_codes.push_back(next_event(now_ms, levels));
		endfunction

		function void match_event(logic [CODE_W-1:0] code);
			logic [CODE_W-1:0] want;
			if (pending_codes.size() == 0) begin
				errors++;
				$display("%0t: unexpected event transaction, expected none, got %0d", $time, code);
			end else begin
				want = pending_codes.pop_front();
				if (code !== want) begin
					errors++;
					$display("%0t: event_code mismatch, expected %0d, got %0d", $time, want, code);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_DEBOUNCE;
	logic [15:0] cfg_data = '0;

	button_event_tracker tracker;
	bit calm = 1'b0;
	int stall_left = 0;
	int polls_sent = 0;
	int t_deb = DEBOUNCE_RST;
	int t_rs = REPEAT_START_RST;
	int t_ri = REPEAT_INTERVAL_RST;
	int t_lp = LONG_PRESS_RST;
	logic [TIME_W-1:0] now_cur;
	logic [LEVEL_W-1:0] lv_cur;

	four_button_debounce_event_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.set_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_poll(s_axis_tdata[31:0], s_axis_tdata[35:32]);
			if (m_axis_tvalid && m_axis_tready)
				tracker.match_event(m_axis_tdata[3:0]);
		end
	end

	task automatic send_poll(input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] lv);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, lv, t};
		do
			@(posedge clk);
		while (!s_axis_tready);
		polls_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_timing(input int d, input int rs, input int ri, input int lp);
		write_reg(REG_DEBOUNCE, 16'(d));
		write_reg(REG_REPEAT_START, 16'(rs));
		write_reg(REG_REPEAT_INTERVAL, 16'(ri));
		write_reg(REG_LONG_PRESS, 16'(lp));
		t_deb = d;
		t_rs = rs;
		t_ri = ri;
		t_lp = lp;
	endtask

	task automatic drain_events();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_codes.size() != 0)
			@(posedge clk);
		repeat (2 + 3 * NUM_BUTTONS_DEF + 2)
			@(posedge clk);
	endtask

	// Presses and releases with contact bounce, held for random spans, mixed with stray polls.
	task automatic run_gestures(input int count);
		int stop;
		int span;
		int bounces;
		int hold;
		int k;
		logic [LEVEL_W-1:0] target;
		stop = polls_sent + count;
		span = t_deb;
		if (t_ri > span)
			span = t_ri;
		if (t_rs / 4 > span)
			span = t_rs / 4;
		if (t_lp / 6 > span)
			span = t_lp / 6;
		span++;
		while (polls_sent < stop) begin
			if ($urandom_range(0, 9) == 0) begin
				send_poll($urandom(), 4'($urandom()));
			end else begin
				if ($urandom_range(0, 9) < 7)
					target = lv_cur ^ (4'b1 << $urandom_range(0, 3));
				else
					target = 4'($urandom());
				bounces = $urandom_range(0, 3);
				for (k = 0; k < bounces; k++) begin
					now_cur += $urandom_range(0, t_deb / 2);
					send_poll(now_cur, (k % 2 == 0) ? target : lv_cur);
				end
				lv_cur = target;
				hold = $urandom_range(2, 14);
				for (k = 0; k < hold; k++) begin
					now_cur += $urandom_range(0, span);
					send_poll(now_cur, lv_cur);
				end
			end
		end
	endtask

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		tracker = new();
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Debounce edge, repeat start and interval edges, long press, release, and
		// a poll that stops at the first button with an event.
		send_poll(0, 4'h0);
		send_poll(10, 4'h1);
		send_poll(60, 4'h1);
		send_poll(61, 4'h1);
		send_poll(560, 4'h1);
		send_poll(561, 4'h1);
		send_poll(661, 4'h1);
		send_poll(1061, 4'h1);
		send_poll(1061, 4'h1);
		send_poll(1100, 4'h0);
		send_poll(1151, 4'h0);
		send_poll(2000, 4'hF);
		repeat (4)
			send_poll(2051, 4'hF);
		repeat (3)
			send_poll(2551, 4'hF);
		repeat (5)
			send_poll(3051, 4'hF);
		send_poll(32'hFFFF_FFFF, 4'hA);
		drain_events();

		now_cur = 32'hFFFF_FFF0;
		lv_cur = 4'hA;
		load_timing(0, 0, 0, 0);
		run_gestures(300);
		drain_events();

		load_timing(65535, 65535, 65535, 65535);
		run_gestures(250);
		drain_events();

		calm = 1'b1;
		load_timing(5, 40, 0, 70);
		run_gestures(350);
		drain_events();
		calm = 1'b0;

		load_timing($urandom_range(0, 200), $urandom_range(0, 3000), $urandom_range(0, 400),
			$urandom_range(0, 4000));
		run_gestures(350);
		drain_events();

		load_timing(65535, 0, 65535, 1);
		run_gestures(250);
		drain_events();

		now_cur = 32'hFFFF_F000;
		load_timing(50, 500, 100, 1000);
		run_gestures(400);
		drain_events();

		if (tracker.errors == 0 && tracker.pending_codes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
